[hw/rtl/mlpd_pkg.sv]
// Shared types and constants for the magic/length packet deframer.
// Used by mlpd_front, mlpd_back and magic_length_packet_deframer.
package mlpd_pkg;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CFG_MAGIC_WORD       = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_PACKET_BYTES = 1'b1;

  localparam logic [31:0] MAGIC_WORD_RST       = 32'd0;
  localparam logic [15:0] MAX_PACKET_BYTES_RST = 16'd4096;

  // Result status codes
  localparam logic [1:0] STATUS_DATA      = 2'd0;
  localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
  localparam logic [1:0] STATUS_TOO_LARGE = 2'd2;
  localparam logic [1:0] STATUS_TOO_SHORT = 2'd3;

  // What the back end has to do with a queue entry
  typedef enum logic [1:0] {
    KIND_BODY,
    KIND_HEADER,
    KIND_ERROR
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data;
    logic        eop;     // for a header: last header byte ends the packet
    logic [1:0]  status;
  } cmd_t;

endpackage

[hw/rtl/magic_length_packet_deframer.sv]
// Packet deframer for a length-prefixed byte stream with a magic word check.
// Top level: mlpd_front -> mlpd_fifo -> mlpd_back. Depends on mlpd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one rx byte per cycle unless
//   stalled, or a restart that drops a partial packet and reopens the link.
//   Output channel (out_valid_o / out_stall_i) gives one packet byte per item,
//   with end_of_packet_o on the last byte, or a single error item (zero byte,
//   end_of_packet_o set, nonzero status_o) after which input is dropped.
//   cfg_we_i writes magic_word (index 0) or max_packet_bytes (index 1).
// Data path: a body byte passes through the queue into the output register.
//   The header is released when its last byte arrives and comes out as
//   HEADER_BYTES items, one per cycle while out_stall_i is low.
// Throughput: one byte per cycle in and out while out_stall_i is low, except
//   around a header burst: the QUEUE_DEPTH command queue holds only the first
//   body bytes, so in_stall_o rises during the burst of a header that is
//   followed by body bytes.
// Reset: link open, no header buffered, queue empty, registers at defaults.
// Output stall: the output register holds; the queue fills and in_stall_o rises
//   once it is full.
module magic_length_packet_deframer #(
  parameter int unsigned HEADER_BYTES = 12,
  parameter int unsigned QUEUE_DEPTH  = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mlpd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [7:0]                   rx_byte_i,
  input  logic                         restart_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [7:0]                   packet_byte_o,
  output logic                         end_of_packet_o,
  output logic [1:0]                   status_o
);

  localparam int unsigned CmdW   = $bits(mlpd_pkg::cmd_t);
  localparam int unsigned EntryW = CmdW + HEADER_BYTES * 8;

  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  mlpd_pkg::cmd_t            front_cmd;
  logic [HEADER_BYTES*8-1:0] front_hdr;
  logic [EntryW-1:0]         q_wdata;
  logic [EntryW-1:0]         q_rdata;
  mlpd_pkg::cmd_t            back_cmd;
  logic [HEADER_BYTES*8-1:0] back_hdr;

  assign q_wdata  = {front_hdr, front_cmd};
  assign back_cmd = mlpd_pkg::cmd_t'(q_rdata[CmdW-1:0]);
  assign back_hdr = q_rdata[EntryW-1:CmdW];

  mlpd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .restart_i  (restart_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_cmd_o    (front_cmd),
    .q_hdr_o    (front_hdr)
  );

  mlpd_fifo #(
    .WIDTH(EntryW),
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .wdata_i (q_wdata),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  mlpd_back #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .q_pop_o         (q_pop),
    .q_cmd_i         (back_cmd),
    .q_hdr_i         (back_hdr),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .packet_byte_o   (packet_byte_o),
    .end_of_packet_o (end_of_packet_o),
    .status_o        (status_o)
  );

endmodule

[hw/rtl/mlpd_fifo.sv]
// Small queue between the deframer front and back ends.
// Generic width and depth; no package dependency.
module mlpd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             full_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = pop_i ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni) push_i |-> !full_o)
    else $error("mlpd_fifo: push into full queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> !empty_o)
    else $error("mlpd_fifo: pop from empty queue");
`endif

endmodule

[hw/rtl/mlpd_front.sv]
// Deframer front end: config registers, header buffering and checks, body count.
// Turns body bytes and complete headers into queue commands. Depends on mlpd_pkg.
module mlpd_front #(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mlpd_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       rx_byte_i,
  input  logic                             restart_i,
  input  logic                             q_full_i,
  output logic                             q_push_o,
  output mlpd_pkg::cmd_t                   q_cmd_o,
  output logic [HEADER_BYTES*8-1:0]        q_hdr_o
);

  localparam int unsigned PosW = $clog2(HEADER_BYTES);

  logic [31:0]     magic_word_q;
  logic [15:0]     max_packet_bytes_q;
  logic [7:0]      store_q [HEADER_BYTES-1];
  logic [PosW-1:0] pos_q, pos_d;
  logic [15:0]     left_q, left_d;
  logic            closed_q, closed_d;
  logic            store_we;
  logic            accept;
  logic [HEADER_BYTES*8-1:0] hdr_full;
  logic [31:0]     magic_rx;
  logic [31:0]     length_rx;
  logic [31:0]     body_len;
  logic [1:0]      check_status;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Complete header as seen when its last byte is on the input
  always_comb begin
    for (int i = 0; i < HEADER_BYTES - 1; i++) begin
      hdr_full[i*8 +: 8] = store_q[i];
    end
    hdr_full[HEADER_BYTES*8-1 -: 8] = rx_byte_i;
  end

  assign magic_rx  = hdr_full[31:0];
  assign length_rx = hdr_full[63:32];
  assign body_len  = length_rx - 32'(HEADER_BYTES);
  assign q_hdr_o   = hdr_full;

  always_comb begin
    priority if (magic_rx != magic_word_q) begin
      check_status = mlpd_pkg::STATUS_BAD_MAGIC;
    end else if (length_rx > {16'd0, max_packet_bytes_q}) begin
      check_status = mlpd_pkg::STATUS_TOO_LARGE;
    end else if (length_rx < 32'(HEADER_BYTES)) begin
      check_status = mlpd_pkg::STATUS_TOO_SHORT;
    end else begin
      check_status = mlpd_pkg::STATUS_DATA;
    end
  end

  always_comb begin
    pos_d    = pos_q;
    left_d   = left_q;
    closed_d = closed_q;
    store_we = 1'b0;
    q_push_o = 1'b0;
    q_cmd_o  = '{kind: mlpd_pkg::KIND_BODY, data: rx_byte_i, eop: 1'b0,
                 status: mlpd_pkg::STATUS_DATA};
    if (accept) begin
      priority if (restart_i) begin
        pos_d    = '0;
        left_d   = '0;
        closed_d = 1'b0;
      end else if (closed_q) begin
        // byte dropped
      end else if (left_q != 16'd0) begin
        left_d      = left_q - 16'd1;
        q_push_o    = 1'b1;
        q_cmd_o.eop = (left_q == 16'd1);
      end else if (pos_q != PosW'(HEADER_BYTES - 1)) begin
        store_we = 1'b1;
        pos_d    = pos_q + PosW'(1);
      end else begin
        pos_d    = '0;
        q_push_o = 1'b1;
        if (check_status != mlpd_pkg::STATUS_DATA) begin
          closed_d       = 1'b1;
          left_d         = '0;
          q_cmd_o.kind   = mlpd_pkg::KIND_ERROR;
          q_cmd_o.data   = 8'd0;
          q_cmd_o.eop    = 1'b1;
          q_cmd_o.status = check_status;
        end else begin
          left_d       = body_len[15:0];
          q_cmd_o.kind = mlpd_pkg::KIND_HEADER;
          q_cmd_o.eop  = (body_len[15:0] == 16'd0);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_word_q       <= mlpd_pkg::MAGIC_WORD_RST;
      max_packet_bytes_q <= mlpd_pkg::MAX_PACKET_BYTES_RST;
      pos_q              <= '0;
      left_q             <= '0;
      closed_q           <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mlpd_pkg::CFG_MAGIC_WORD:       magic_word_q       <= cfg_data_i;
          mlpd_pkg::CFG_MAX_PACKET_BYTES: max_packet_bytes_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      pos_q    <= pos_d;
      left_q   <= left_d;
      closed_q <= closed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[pos_q] <= rx_byte_i;
    end
  end

endmodule

[hw/rtl/mlpd_back.sv]
// Deframer back end: drains queue commands into the output register,
// serializing a checked header into one item per byte. Depends on mlpd_pkg.
module mlpd_back #(
  parameter int unsigned HEADER_BYTES = 12
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_empty_i,
  output logic                      q_pop_o,
  input  mlpd_pkg::cmd_t            q_cmd_i,
  input  logic [HEADER_BYTES*8-1:0] q_hdr_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [7:0]                packet_byte_o,
  output logic                      end_of_packet_o,
  output logic [1:0]                status_o
);

  localparam int unsigned CntW = $clog2(HEADER_BYTES);
  localparam int unsigned SrW  = (HEADER_BYTES - 1) * 8;

  logic            busy_q, busy_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [SrW-1:0]  sr_q, sr_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            eop_q, eop_d;
  logic [1:0]      status_q, status_d;
  logic            load;

  assign load    = !out_valid_q || !out_stall_i;
  assign q_pop_o = load && !busy_q && !q_empty_i;

  assign out_valid_o     = out_valid_q;
  assign packet_byte_o   = byte_q;
  assign end_of_packet_o = eop_q;
  assign status_o        = status_q;

  always_comb begin
    busy_d      = busy_q;
    cnt_d       = cnt_q;
    sr_d        = sr_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    eop_d       = eop_q;
    status_d    = status_q;
    if (load) begin
      if (busy_q) begin
        out_valid_d = 1'b1;
        byte_d      = sr_q[7:0];
        status_d    = mlpd_pkg::STATUS_DATA;
        sr_d        = sr_q >> 8;
        cnt_d       = cnt_q + CntW'(1);
        eop_d       = 1'b0;
        if (cnt_q == CntW'(HEADER_BYTES - 1)) begin
          eop_d  = last_q;
          busy_d = 1'b0;
        end
      end else if (!q_empty_i) begin
        out_valid_d = 1'b1;
        unique case (q_cmd_i.kind)
          mlpd_pkg::KIND_HEADER: begin
            byte_d   = q_hdr_i[7:0];
            eop_d    = 1'b0;
            status_d = mlpd_pkg::STATUS_DATA;
            sr_d     = q_hdr_i[HEADER_BYTES*8-1:8];
            cnt_d    = CntW'(1);
            last_d   = q_cmd_i.eop;
            busy_d   = 1'b1;
          end
          default: begin
            byte_d   = q_cmd_i.data;
            eop_d    = q_cmd_i.eop;
            status_d = q_cmd_i.status;
          end
        endcase
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q    <= cnt_d;
    sr_q     <= sr_d;
    last_q   <= last_d;
    byte_q   <= byte_d;
    eop_q    <= eop_d;
    status_q <= status_d;
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && (status_o != mlpd_pkg::STATUS_DATA)
      |-> end_of_packet_o && (packet_byte_o == 8'd0))
    else $error("mlpd_back: error item not a zero byte ending the packet");
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy_q |-> !q_pop_o)
    else $error("mlpd_back: queue popped during header burst");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q && load |=> out_valid_q && (status_q == mlpd_pkg::STATUS_DATA))
    else $error("mlpd_back: header burst produced no data item");
`endif

endmodule

[tb/sv/magic_length_packet_deframer_tb.sv]
// Self-checking testbench for magic_length_packet_deframer.
// Byte-level predictor, valid/stall driver and monitor; depends on mlpd_pkg.
module magic_length_packet_deframer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDR_LEN    = 12;
  localparam int unsigned CYCLE_CAP  = 200000;
  localparam int unsigned SETTLE_CYC = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       drain;    // sender holds this item until nothing is outstanding
  } rx_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eop;
    logic [1:0] status;
  } frame_byte_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_HALF,
    STALL_RARE,
    STALL_HEAVY
  } stall_mode_e;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [mlpd_pkg::CfgIdxW-1:0] cfg_idx_i = mlpd_pkg::CFG_MAGIC_WORD;
  logic [31:0]                  cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic [7:0]                   rx_byte_i = '0;
  logic                         restart_i = 1'b0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [7:0]                   packet_byte_o;
  logic                         end_of_packet_o;
  logic [1:0]                   status_o;

  rx_item_t    rx_q[$];
  frame_byte_t frame_q[$];
  frame_byte_t want_byte;
  rx_item_t    next_rx;

  // predictor state
  logic [31:0] cfg_magic = mlpd_pkg::MAGIC_WORD_RST;
  logic [15:0] cfg_max   = mlpd_pkg::MAX_PACKET_BYTES_RST;
  logic [7:0]  hdr_buf[HDR_LEN];
  int unsigned hdr_fill  = 0;
  logic [15:0] body_left = '0;
  bit          link_down = 1'b0;

  int unsigned err_count   = 0;
  int unsigned cycle_count = 0;
  int unsigned planned     = 0;
  int unsigned burst_left  = 0;
  int unsigned gap_left    = 0;
  int unsigned mode_left   = 0;
  stall_mode_e stall_mode  = STALL_NONE;

  magic_length_packet_deframer #(
    .HEADER_BYTES(HDR_LEN)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .rx_byte_i      (rx_byte_i),
    .restart_i      (restart_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .packet_byte_o  (packet_byte_o),
    .end_of_packet_o(end_of_packet_o),
    .status_o       (status_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic void add_expected(input frame_byte_t fb);
    frame_q.insert(frame_q.size(), fb);
  endfunction

  function automatic void add_rx(input rx_item_t it);
    rx_q.insert(rx_q.size(), it);
  endfunction

  // Expected packet bytes for one accepted input item
  task automatic deframe_byte(input logic [7:0] b, input logic rs);
    logic [31:0] magic_seen;
    logic [31:0] pkt_len;
    logic [1:0]  st;
    if (rs) begin
      hdr_fill  = 0;
      body_left = '0;
      link_down = 1'b0;
    end else if (link_down) begin
      // closed link: item dropped
    end else if (body_left != 0) begin
      body_left = body_left - 16'd1;
      add_expected('{data: b, eop: (body_left == 0), status: mlpd_pkg::STATUS_DATA});
    end else begin
      hdr_buf[hdr_fill] = b;
      hdr_fill++;
      if (hdr_fill == HDR_LEN) begin
        hdr_fill   = 0;
        magic_seen = {hdr_buf[3], hdr_buf[2], hdr_buf[1], hdr_buf[0]};
        pkt_len    = {hdr_buf[7], hdr_buf[6], hdr_buf[5], hdr_buf[4]};
        st         = mlpd_pkg::STATUS_DATA;
        if (magic_seen != cfg_magic)
          st = mlpd_pkg::STATUS_BAD_MAGIC;
        else if (pkt_len > {16'd0, cfg_max})
          st = mlpd_pkg::STATUS_TOO_LARGE;
        else if (pkt_len < HDR_LEN)
          st = mlpd_pkg::STATUS_TOO_SHORT;
        if (st != mlpd_pkg::STATUS_DATA) begin
          link_down = 1'b1;
          body_left = '0;
          add_expected('{data: 8'h00, eop: 1'b1, status: st});
        end else begin
          body_left = pkt_len[15:0] - 16'(HDR_LEN);
          for (int i = 0; i < HDR_LEN; i++)
            add_expected('{data: hdr_buf[i],
                           eop: (i == HDR_LEN - 1) && (body_left == 0),
                           status: mlpd_pkg::STATUS_DATA});
        end
      end
    end
  endtask

  // Sender: bursts of items with random gaps; a drain item waits for the output side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      rx_byte_i  <= '0;
      restart_i  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else if (!in_valid_i || !in_stall_o) begin
      if (gap_left != 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (rx_q.size() == 0 ||
                   (rx_q[0].drain && (in_valid_i || frame_q.size() != 0))) begin
        in_valid_i <= 1'b0;
      end else begin
        next_rx = rx_q.pop_front();
        rx_byte_i  <= next_rx.data;
        restart_i  <= next_rx.restart;
        in_valid_i <= 1'b1;
        if (burst_left != 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 8) : 0;
        end
      end
    end
  end

  // Receiver stall pattern: a randomly chosen mode, redrawn once its run is used up
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      mode_left  = 0;
      stall_mode = STALL_NONE;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        mode_left  = $urandom_range(16, 96);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        STALL_NONE: out_stall_i <= 1'b0;
        STALL_HALF: out_stall_i <= 1'($urandom_range(0, 1));
        STALL_RARE: out_stall_i <= ($urandom_range(0, 7) == 0);
        default:    out_stall_i <= ($urandom_range(0, 15) < 12);
      endcase
    end
  end

  // Monitor: check results against the oldest expectation, then predict accepted input
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (frame_q.size() == 0) begin
        $error("unexpected item: packet_byte %0h end_of_packet %0b status %0d",
               packet_byte_o, end_of_packet_o, status_o);
        err_count++;
      end else begin
        want_byte = frame_q.pop_front();
        if (packet_byte_o !== want_byte.data) begin
          $error("packet_byte: expected %0h, got %0h", want_byte.data, packet_byte_o);
          err_count++;
        end
        if (end_of_packet_o !== want_byte.eop) begin
          $error("end_of_packet: expected %0b, got %0b", want_byte.eop, end_of_packet_o);
          err_count++;
        end
        if (status_o !== want_byte.status) begin
          $error("status: expected %0d, got %0d", want_byte.status, status_o);
          err_count++;
        end
      end
    end
    if (rst_ni && in_valid_i && !in_stall_o)
      deframe_byte(rx_byte_i, restart_i);
  end

  task automatic push_rx(input logic [7:0] b, input logic rs, input bit drain);
    add_rx('{data: b, restart: rs, drain: drain || ($urandom_range(0, 29) == 0)});
    if (!rs) planned++;
  endtask

  task automatic push_restart();
    push_rx(8'($urandom_range(0, 255)), 1'b1, 1'b0);
  endtask

  // Header (magic, length, four pass-through bytes) followed by body bytes
  task automatic push_frame(input logic [31:0] mag, input logic [31:0] len, input int nbody);
    for (int i = 0; i < 4; i++) push_rx(mag[8*i +: 8], 1'b0, 1'b0);
    for (int i = 0; i < 4; i++) push_rx(len[8*i +: 8], 1'b0, 1'b0);
    for (int i = 0; i < 4 + nbody; i++) push_rx(8'($urandom_range(0, 255)), 1'b0, 1'b0);
  endtask

  // Bytes on a closed link, then reopen
  task automatic push_dropped_tail();
    int n;
    n = $urandom_range(0, 3);
    for (int i = 0; i < n; i++) add_rx('{data: 8'($urandom_range(0, 255)),
                                         restart: 1'b0, drain: 1'b0});
    push_restart();
  endtask

  task automatic fill_random(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned lim;
    logic [31:0] len;
    int          nb;
    start = planned;
    push_rx(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    while (planned - start < n_items) begin
      pick = $urandom_range(0, 99);
      lim  = (cfg_max < 36) ? cfg_max : 36;
      if (pick < 60) begin
        len = $urandom_range(HDR_LEN, lim);
        push_frame(cfg_magic, len, len - HDR_LEN);
      end else if (pick < 65) begin
        // longest legal packet where that stays short, else a header, up to four body bytes and a restart
        if (cfg_max <= 64) begin
          push_frame(cfg_magic, cfg_max, cfg_max - HDR_LEN);
        end else begin
          push_frame(cfg_magic, cfg_max, $urandom_range(0, 4));
          push_restart();
        end
      end else if (pick < 70) begin
        push_frame(cfg_magic ^ (32'h1 << $urandom_range(0, 31)),
                   $urandom_range(HDR_LEN, lim), 0);
        push_dropped_tail();
      end else if (pick < 75) begin
        case ($urandom_range(0, 2))
          0:       len = 32'hFFFF_FFFF;
          1:       len = {16'd0, cfg_max} + 32'd1;
          default: len = $urandom() | 32'h0001_0000;
        endcase
        push_frame(cfg_magic, len, 0);
        push_dropped_tail();
      end else if (pick < 80) begin
        push_frame(cfg_magic, $urandom_range(0, HDR_LEN - 1), 0);
        push_dropped_tail();
      end else if (pick < 88) begin
        nb = $urandom_range(1, HDR_LEN - 1);
        for (int i = 0; i < nb; i++) push_rx(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        push_restart();
      end else if (pick < 94) begin
        // restart in the middle of a body
        if (cfg_max > HDR_LEN) begin
          len = $urandom_range(HDR_LEN + 1, cfg_max);
          nb  = $urandom_range(0, (len - HDR_LEN - 1 < 20) ? len - HDR_LEN - 1 : 20);
          push_frame(cfg_magic, len, nb);
        end else begin
          push_frame(cfg_magic, HDR_LEN, 0);
        end
        push_restart();
      end else begin
        nb = $urandom_range(1, 15);
        for (int i = 0; i < nb; i++)
          push_rx(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0), 1'b0);
        push_restart();
      end
    end
    // leave the deframer in a clean state before the next register write
    push_restart();
  endtask

  task automatic wait_drained();
    do @(posedge clk_i);
    while (rx_q.size() != 0 || in_valid_i || frame_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [mlpd_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == mlpd_pkg::CFG_MAGIC_WORD)
      cfg_magic = val;
    else
      cfg_max = val[15:0];
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: header-only packet, then bad magic, a dropped byte and a restart
    push_frame(mlpd_pkg::MAGIC_WORD_RST, HDR_LEN, 0);
    push_frame(32'h0000_0001, HDR_LEN, 0);
    add_rx('{data: 8'hFF, restart: 1'b0, drain: 1'b0});
    push_restart();
    fill_random(40);
    wait_drained();

    write_reg(mlpd_pkg::CFG_MAGIC_WORD, 32'hFFFF_FFFF);
    write_reg(mlpd_pkg::CFG_MAX_PACKET_BYTES, 32'd65535);
    fill_random(55);
    wait_drained();

    write_reg(mlpd_pkg::CFG_MAX_PACKET_BYTES, 32'(HDR_LEN));
    write_reg(mlpd_pkg::CFG_MAGIC_WORD, $urandom());
    fill_random(40);
    wait_drained();

    write_reg(mlpd_pkg::CFG_MAGIC_WORD, $urandom());
    write_reg(mlpd_pkg::CFG_MAX_PACKET_BYTES, $urandom_range(HDR_LEN + 1, 40));
    fill_random(55);
    wait_drained();

    write_reg(mlpd_pkg::CFG_MAX_PACKET_BYTES, $urandom_range(HDR_LEN, 65535));
    write_reg(mlpd_pkg::CFG_MAGIC_WORD, $urandom());
    fill_random(65);
    wait_drained();

    repeat (20) @(posedge clk_i);
    if (frame_q.size() != 0) begin
      $error("%0d expected items never arrived", frame_q.size());
      err_count++;
    end
    if (err_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
hw/rtl/mlpd_pkg.sv
hw/rtl/mlpd_fifo.sv
hw/rtl/mlpd_front.sv
hw/rtl/mlpd_back.sv
hw/rtl/magic_length_packet_deframer.sv
tb/sv/magic_length_packet_deframer_tb.sv
